### sv/olpfd_pkg.sv
// Package for the ordered list block: codes, command type and engine states.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package olpfd_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int OPCODE_W    = 2;

    // command queue between front and back, power-of-two depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [OPCODE_W-1:0] OPC_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_LIST,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_LST_RD,
        S_LST_OUT,
        S_RSP
    } t_state;

endpackage

`default_nettype wire

### sv/olpfd_if.sv
// Request and response channel interfaces of the ordered list block.
// Depends on olpfd_pkg for field widths.
`default_nettype none

interface olpfd_req_if;
    logic                                 valid;
    logic                                 ready;
    logic        [olpfd_pkg::OPCODE_W-1:0] opcode;
    logic signed [olpfd_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface olpfd_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic        [olpfd_pkg::STATUS_W-1:0] status;
    logic signed [olpfd_pkg::VALUE_W-1:0]  entry_value;
    logic                                 last;

    modport source (output valid, output status, output entry_value, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input last,
                    output ready);
endinterface

`default_nettype wire

### sv/olpfd_front.sv
// Front end: takes requests, decodes the opcode into a command, holds it in a register.
// Depends on olpfd_pkg and olpfd_req_if.
`default_nettype none

module olpfd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    olpfd_req_if.sink         i_req,
    output logic              o_cmd_valid,
    output olpfd_pkg::t_cmd   o_cmd,
    input  wire               i_cmd_ready
);

    logic            r_valid;
    olpfd_pkg::t_cmd r_cmd;
    olpfd_pkg::t_cmd n_cmd;

    assign i_req.ready = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.value = i_req.value;
        unique case (i_req.opcode)
            olpfd_pkg::OPC_INSERT: n_cmd.op = olpfd_pkg::OP_INSERT;
            olpfd_pkg::OPC_DELETE: n_cmd.op = olpfd_pkg::OP_DELETE;
            olpfd_pkg::OPC_LIST:   n_cmd.op = olpfd_pkg::OP_LIST;
            default:               n_cmd.op = olpfd_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/olpfd_queue.sv
// Short command FIFO between the front end and the list engine.
// Depends on olpfd_pkg.
`default_nettype none

module olpfd_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push_valid,
    input  olpfd_pkg::t_cmd   i_push_cmd,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output olpfd_pkg::t_cmd   o_pop_cmd,
    input  wire               i_pop_ready
);

    olpfd_pkg::t_cmd                   r_mem [olpfd_pkg::QUEUE_DEPTH];
    logic [olpfd_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [olpfd_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [olpfd_pkg::QUEUE_AW:0]      r_count;
    logic                              push;
    logic                              pop;

    assign o_push_ready = (r_count != (olpfd_pkg::QUEUE_AW+1)'(olpfd_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

### sv/olpfd_back.sv
// List engine: entry memory, search/compaction/listing sequencer and result register.
// Depends on olpfd_pkg and olpfd_rsp_if.
`default_nettype none

module olpfd_back #(
    parameter int MAX_ENTRIES = olpfd_pkg::MAX_ENTRIES
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cmd_valid,
    input  olpfd_pkg::t_cmd   i_cmd,
    output logic              o_cmd_ready,
    olpfd_rsp_if.source       o_rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int VW = olpfd_pkg::VALUE_W;
    localparam int SW = olpfd_pkg::STATUS_W;

    // slot 0 is the back of the list, slot count-1 the front
    logic signed [VW-1:0]  r_mem [MAX_ENTRIES];
    logic signed [VW-1:0]  r_rd_data;

    olpfd_pkg::t_state     r_state;
    olpfd_pkg::t_state     n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         n_idx;
    logic signed [VW-1:0]  r_value;
    logic signed [VW-1:0]  n_value;
    logic [SW-1:0]         r_status;
    logic [SW-1:0]         n_status;

    logic                  r_out_valid;
    logic [SW-1:0]         r_out_status;
    logic signed [VW-1:0]  r_out_value;
    logic                  r_out_last;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic signed [VW-1:0]  wr_data;
    logic                  out_load;
    logic [SW-1:0]         out_status;
    logic signed [VW-1:0]  out_value;
    logic                  out_last;

    logic                  slot_free;
    logic                  take_cmd;
    logic                  is_full;
    logic                  is_empty;
    logic                  match;
    logic                  at_back;
    logic                  pos_is_front;
    logic                  shift_done;

    assign slot_free    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready  = (r_state == olpfd_pkg::S_IDLE);
    assign take_cmd     = i_cmd_valid && o_cmd_ready;
    assign is_full      = (r_count == CW'(MAX_ENTRIES));
    assign is_empty     = (r_count == '0);
    assign match        = (r_rd_data == r_value);
    assign at_back      = (r_idx == '0);
    assign pos_is_front = ((r_idx + 1'b1) == r_count);
    assign shift_done   = ((r_idx + CW'(2)) == r_count);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_value = r_out_value;
    assign o_rsp.last        = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olpfd_pkg::S_IDLE: begin
                if (take_cmd) begin
                    case (i_cmd.op)
                        olpfd_pkg::OP_DELETE:
                            n_state = is_empty ? olpfd_pkg::S_RSP : olpfd_pkg::S_DEL_RD;
                        olpfd_pkg::OP_LIST:
                            n_state = is_empty ? olpfd_pkg::S_RSP : olpfd_pkg::S_LST_RD;
                        default:
                            n_state = olpfd_pkg::S_RSP;
                    endcase
                end
            end
            olpfd_pkg::S_DEL_RD:  n_state = olpfd_pkg::S_DEL_CMP;
            olpfd_pkg::S_DEL_CMP: begin
                if (match) begin
                    n_state = pos_is_front ? olpfd_pkg::S_RSP : olpfd_pkg::S_SH_RD;
                end else begin
                    n_state = at_back ? olpfd_pkg::S_RSP : olpfd_pkg::S_DEL_RD;
                end
            end
            olpfd_pkg::S_SH_RD:   n_state = olpfd_pkg::S_SH_WR;
            olpfd_pkg::S_SH_WR:
                n_state = shift_done ? olpfd_pkg::S_RSP : olpfd_pkg::S_SH_RD;
            olpfd_pkg::S_LST_RD:  n_state = olpfd_pkg::S_LST_OUT;
            olpfd_pkg::S_LST_OUT: begin
                if (slot_free) begin
                    n_state = at_back ? olpfd_pkg::S_IDLE : olpfd_pkg::S_LST_RD;
                end
            end
            olpfd_pkg::S_RSP: begin
                if (slot_free) begin
                    n_state = olpfd_pkg::S_IDLE;
                end
            end
            default: n_state = olpfd_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_count    = r_count;
        n_idx      = r_idx;
        n_value    = r_value;
        n_status   = r_status;
        rd_en      = 1'b0;
        rd_addr    = r_idx[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_idx[AW-1:0];
        wr_data    = r_rd_data;
        out_load   = 1'b0;
        out_status = r_status;
        out_value  = '0;
        out_last   = 1'b1;
        unique case (r_state)
            olpfd_pkg::S_IDLE: begin
                if (take_cmd) begin
                    n_value = i_cmd.value;
                    n_idx   = r_count - 1'b1;
                    case (i_cmd.op)
                        olpfd_pkg::OP_INSERT: begin
                            if (is_full) begin
                                n_status = olpfd_pkg::ST_FULL;
                            end else begin
                                wr_en    = 1'b1;
                                wr_addr  = r_count[AW-1:0];
                                wr_data  = i_cmd.value;
                                n_count  = r_count + 1'b1;
                                n_status = olpfd_pkg::ST_DONE;
                            end
                        end
                        olpfd_pkg::OP_DELETE: n_status = olpfd_pkg::ST_NOT_FOUND;
                        olpfd_pkg::OP_LIST:   n_status = olpfd_pkg::ST_EMPTY;
                        default:              n_status = olpfd_pkg::ST_DONE;
                    endcase
                end
            end
            olpfd_pkg::S_DEL_RD: begin
                rd_en = 1'b1;
            end
            olpfd_pkg::S_DEL_CMP: begin
                if (match) begin
                    n_status = olpfd_pkg::ST_DONE;
                    if (pos_is_front) begin
                        n_count = r_count - 1'b1;
                    end
                end else if (!at_back) begin
                    n_idx = r_idx - 1'b1;
                end
            end
            olpfd_pkg::S_SH_RD: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_idx + 1'b1);
            end
            olpfd_pkg::S_SH_WR: begin
                wr_en = 1'b1;
                n_idx = r_idx + 1'b1;
                if (shift_done) begin
                    n_count = r_count - 1'b1;
                end
            end
            olpfd_pkg::S_LST_RD: begin
                rd_en = 1'b1;
            end
            olpfd_pkg::S_LST_OUT: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = olpfd_pkg::ST_ENTRY;
                    out_value  = r_rd_data;
                    out_last   = at_back;
                    if (!at_back) begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            olpfd_pkg::S_RSP: begin
                out_load = slot_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= olpfd_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_status <= n_status;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_value  <= out_value;
            r_out_last   <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/ordered_list_push_front_delete.sv
// Top level of the ordered list block: front end, command queue, list engine.
// Depends on olpfd_pkg, olpfd_if, olpfd_front, olpfd_queue, olpfd_back.
//
//  Channel  Dir  Fields                          Request accepted when
//  i_req    in   opcode[1:0], value[31:0]        i_req.valid && i_req.ready
//  o_rsp    out  status[2:0], entry_value[31:0], o_rsp.valid && o_rsp.ready
//                last
//
// Insert, no-op and empty-list requests: front register, queue, then the result load.
// Delete reads and compares each entry scanned from the front, then reads and writes each
// entry shifted behind the match; the read of the entry memory is registered.
// List: each entry emitted takes a memory read and a result load, held while o_rsp stalls.
// Reset is synchronous, active low; entry memory contents are not cleared.
// Front register and 2-deep queue keep accepting while the engine works or o_rsp stalls, until full.
`default_nettype none

module ordered_list_push_front_delete #(
    parameter int MAX_ENTRIES = olpfd_pkg::MAX_ENTRIES
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    olpfd_req_if.sink    i_req,
    olpfd_rsp_if.source  o_rsp
);

    logic            front_valid;
    olpfd_pkg::t_cmd front_cmd;
    logic            front_ready;
    logic            queue_valid;
    olpfd_pkg::t_cmd queue_cmd;
    logic            queue_ready;

    olpfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    olpfd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_cmd    (queue_cmd),
        .i_pop_ready  (queue_ready)
    );

    olpfd_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_ready (queue_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

### sv/olpfd_checker.sv
// Port-level checks on the response channel of the ordered list block, and its bind.
// Depends on olpfd_pkg and the top level ordered_list_push_front_delete.
`default_nettype none

module olpfd_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_rsp_valid,
    input wire                               i_rsp_ready,
    input wire [olpfd_pkg::STATUS_W-1:0]     i_rsp_status,
    input wire [olpfd_pkg::VALUE_W-1:0]      i_rsp_entry_value,
    input wire                               i_rsp_last
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_status) && $stable(i_rsp_entry_value) && $stable(i_rsp_last))
        else $error("response payload changed while stalled");

    a_status_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != olpfd_pkg::ST_ENTRY) |-> (i_rsp_entry_value == '0))
        else $error("nonzero value on a non-list response");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != olpfd_pkg::ST_ENTRY) |-> i_rsp_last)
        else $error("single-result request without last");

endmodule

bind ordered_list_push_front_delete olpfd_checker u_olpfd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_entry_value (o_rsp.entry_value),
    .i_rsp_last        (o_rsp.last)
);

`default_nettype wire
